FILE: src/shk_pkg.sv
package shk_pkg;

  localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
  localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef struct packed {
    logic [63:0] blk;
    logic        fin;
  } blk_entry_t;

  typedef struct packed {
    logic       write;
    logic       index;
    logic [63:0] data;
  } cfg_write_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    a = s.v0;
    b = s.v1;
    c = s.v2;
    d = s.v3;
    a = a + b; b = rotl(b, 13); b = b ^ a; a = rotl(a, 32);
    c = c + d; d = rotl(d, 16); d = d ^ c;
    a = a + d; d = rotl(d, 21); d = d ^ a;
    c = c + b; b = rotl(b, 17); b = b ^ c; c = rotl(c, 32);
    sip_round = '{v0: a, v1: b, v2: c, v3: d};
  endfunction

  function automatic sip_state_t sip_absorb(input sip_state_t s, input logic [63:0] m);
    sip_state_t t;
    t = s;
    t.v3 = t.v3 ^ m;
    t = sip_round(t);
    t = sip_round(t);
    t.v0 = t.v0 ^ m;
    sip_absorb = t;
  endfunction

  function automatic sip_state_t sip_init(input logic [63:0] k0, input logic [63:0] k1);
    sip_init = '{v0: SIP_C0 ^ k0, v1: SIP_C1 ^ k1, v2: SIP_C2 ^ k0, v3: SIP_C3 ^ k1};
  endfunction

endpackage

FILE: src/shk_front.sv
module shk_front
  import shk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] message_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last_word,
  output logic        push,
  output blk_entry_t  push_entry,
  input  logic        q_full
);

  logic [7:0]  byte_total;
  logic        pending;
  logic [63:0] pending_blk;
  logic [3:0]  vb_eff;
  logic [7:0]  total_plus8;
  logic [7:0]  total_plus_vb;
  logic [63:0] tail;
  logic        accept;
  logic        full_word;

  always_comb begin
    vb_eff = valid_bytes[3] ? 4'd8 : valid_bytes;
    full_word = !last_word || vb_eff[3];
    total_plus8 = byte_total + 8'd8;
    total_plus_vb = byte_total + {4'd0, vb_eff};
    for (int i = 0; i < 8; i++) begin
      tail[8*i +: 8] = (4'(i) < vb_eff) ? message_word[8*i +: 8] : 8'd0;
    end
  end

  assign in_ready = !pending && !q_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    push = 1'b0;
    push_entry = '{blk: message_word, fin: 1'b0};
    if (pending) begin
      push = !q_full;
      push_entry = '{blk: pending_blk, fin: 1'b1};
    end else if (accept) begin
      push = 1'b1;
      if (!full_word) begin
        push_entry = '{blk: {total_plus_vb, tail[55:0]}, fin: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_total <= 8'd0;
      pending <= 1'b0;
    end else begin
      if (pending && !q_full) begin
        pending <= 1'b0;
      end
      if (accept) begin
        if (!last_word) begin
          byte_total <= total_plus8;
        end else begin
          byte_total <= 8'd0;
          if (full_word) begin
            pending <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_word && full_word) begin
      pending_blk <= {total_plus8, 56'd0};
    end
  end

endmodule

FILE: src/shk_queue.sv
module shk_queue
  import shk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       push,
  input  blk_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output blk_entry_t head
);

  blk_entry_t           slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

FILE: src/shk_back.sv
module shk_back
  import shk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_write_t  cfg,
  input  logic        q_empty,
  input  blk_entry_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  sip_state_t  v;
  sip_state_t  absorbed;
  sip_state_t  fin_a;
  sip_state_t  fin_b;
  sip_state_t  fin_b_next;
  sip_state_t  fin_c;
  logic        fin_a_valid;
  logic        fin_b_valid;
  logic        out_free;
  logic        fin_b_ready;
  logic        fin_a_ready;
  logic [63:0] key_low_next;
  logic [63:0] key_high_next;

  assign out_free    = !out_valid || out_ready;
  assign fin_b_ready = !fin_b_valid || out_free;
  assign fin_a_ready = !fin_a_valid || fin_b_ready;
  assign pop = !q_empty && (!head.fin || fin_a_ready);

  always_comb begin
    absorbed = sip_absorb(v, head.blk);
    fin_b_next = sip_round(sip_round(fin_a));
    fin_c = sip_round(sip_round(fin_b));
    key_low_next = (cfg.index == REG_KEY_LOW) ? cfg.data : key_low;
    key_high_next = (cfg.index == REG_KEY_HIGH) ? cfg.data : key_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= 64'd0;
      key_high <= 64'd0;
      v <= sip_init(64'd0, 64'd0);
    end else if (cfg.write) begin
      key_low <= key_low_next;
      key_high <= key_high_next;
      v <= sip_init(key_low_next, key_high_next);
    end else if (pop) begin
      if (head.fin) begin
        v <= sip_init(key_low, key_high);
      end else begin
        v <= absorbed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_a_valid <= 1'b0;
      fin_b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.fin) begin
        fin_a_valid <= 1'b1;
      end else if (fin_b_ready) begin
        fin_a_valid <= 1'b0;
      end
      if (fin_b_ready) begin
        fin_b_valid <= fin_a_valid;
      end
      if (out_free) begin
        out_valid <= fin_b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.fin) begin
      fin_a <= '{v0: absorbed.v0, v1: absorbed.v1,
                 v2: absorbed.v2 ^ SIP_FIN, v3: absorbed.v3};
    end
    if (fin_b_ready && fin_a_valid) begin
      fin_b <= fin_b_next;
    end
    if (out_free && fin_b_valid) begin
      hash_value <= fin_c.v0 ^ fin_c.v1 ^ fin_c.v2 ^ fin_c.v3;
    end
  end

endmodule

FILE: src/siphash_keyed_stream_hash_top.sv
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words. The
// core absorbs one beat per clock while the queue has room and no length
// block is pending: the two-round compression is combinational and closes
// its loop through the state register. A last beat with 8 valid bytes
// (valid_bytes 8 to 15) is pushed as two blocks (the word, then the length
// block), so tready drops after it until the length block enters the queue;
// a last beat with 0 to 7 bytes pushes one. The four finalization rounds run
// in a two-stage pipeline (fin_a to fin_b, fin_b to the output register)
// behind the compression stage. The first beat of the next message can be
// accepted on the clock after the length block enters the queue. Key writes
// re-initialize the state and abandon any message in progress.
module siphash_keyed_stream_hash_top
  import shk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // message_word[63:0], valid_bytes[67:64], zero pad
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata   // hash_value[63:0]
);

  cfg_write_t cfg;
  logic       push;
  blk_entry_t push_entry;
  logic       q_full;
  logic       q_empty;
  logic       pop;
  blk_entry_t head;

  assign cfg = '{write: cfg_write, index: cfg_index, data: cfg_data};

  shk_front u_front (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .message_word (s_tdata[63:0]),
    .valid_bytes  (s_tdata[67:64]),
    .last_word    (s_tlast),
    .push         (push),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  shk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .clear      (cfg_write),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  shk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hash_value (m_tdata)
  );

endmodule

FILE: tb/tb_siphash_keyed_stream_hash_top.sv
`timescale 1ns / 1ps

module tb_siphash_keyed_stream_hash_top;
  import shk_pkg::*;

  localparam int RANDOM_BEATS = 1450;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int NUM_ROWS = 20;
  localparam int STD_KEY_ROW = 6;
  localparam logic [63:0] STD_KEY_LOW = 64'h0706050403020100;
  localparam logic [63:0] STD_KEY_HIGH = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        typed;
    logic [63:0] hash;
  } beat_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_KEY_LOW;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // message_word[63:0], valid_bytes[67:64], zero pad
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;       // hash_value[63:0]

  siphash_keyed_stream_hash_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] lane [4];
  logic [63:0] key_lo;
  logic [63:0] key_hi;
  logic [7:0]  msg_bytes;

  logic [63:0] pending_hashes [$];
  beat_row_t   script [NUM_ROWS];

  int  errs = 0;
  int  beats = 0;
  int  hashes = 0;
  int  key_writes = 0;
  int  cycles = 0;
  int  sink_hold = 0;
  bit  src_hurry = 1'b0;
  bit  sink_hurry = 1'b0;
  logic [63:0] want;

  function automatic logic [63:0] rol64(input logic [63:0] x, input int n);
    return (x << n) | (x >> (64 - n));
  endfunction

  function automatic void sip_compress();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    a = lane[0]; b = lane[1]; c = lane[2]; d = lane[3];
    a = a + b; b = rol64(b, 13) ^ a; a = rol64(a, 32);
    c = c + d; d = rol64(d, 16) ^ c;
    a = a + d; d = rol64(d, 21) ^ a;
    c = c + b; b = rol64(b, 17) ^ c; c = rol64(c, 32);
    lane[0] = a; lane[1] = b; lane[2] = c; lane[3] = d;
  endfunction

  function automatic void sip_feed(input logic [63:0] m);
    lane[3] = lane[3] ^ m;
    sip_compress();
    sip_compress();
    lane[0] = lane[0] ^ m;
  endfunction

  function automatic void restart_hash();
    lane[0] = SIP_C0 ^ key_lo;
    lane[1] = SIP_C1 ^ key_hi;
    lane[2] = SIP_C2 ^ key_lo;
    lane[3] = SIP_C3 ^ key_hi;
    msg_bytes = '0;
  endfunction

  function automatic bit fold_beat(input logic [63:0] word, input logic [3:0] nb,
                                   input logic last, output logic [63:0] digest);
    logic [3:0]  n;
    logic [63:0] tail;
    n = (nb > 4'd8) ? 4'd8 : nb;
    tail = '0;
    digest = '0;
    if (!last || n == 4'd8) begin
      sip_feed(word);
      msg_bytes = msg_bytes + 8'd8;
      if (!last) return 1'b0;
    end else begin
      if (n != 0) tail = word & ((64'h1 << (8 * n)) - 64'h1);
      msg_bytes = msg_bytes + {4'h0, n};
    end
    sip_feed({msg_bytes, 56'h0} | tail);
    lane[2] = lane[2] ^ SIP_FIN;
    repeat (4) sip_compress();
    digest = lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
    restart_hash();
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_beat(input logic [63:0] word, input logic [3:0] nb, input logic last,
                           input logic typed, input logic [63:0] typed_hash);
    int gap;
    logic [63:0] digest;
    gap = src_hurry ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, nb, word};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    beats++;
    if (fold_beat(word, nb, last, digest))
      pending_hashes.push_back(typed ? typed_hash : digest);
  endtask

  // hold off until every hash is in and the pipeline has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_key(input logic idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_KEY_LOW) key_lo = value;
    else key_hi = value;
    restart_hash();
    key_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_hashes.size() == 0) begin
          $error("unexpected hash_value beat: got %h", m_tdata);
          errs++;
        end else begin
          want = pending_hashes.pop_front();
          if (m_tdata !== want) begin
            $error("hash_value mismatch: expected %h, got %h", want, m_tdata);
            errs++;
          end
          hashes++;
        end
        sink_hold = sink_hurry ? 0 : $urandom_range(0, 12);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      m_tready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("[siphash_keyed_stream_hash_top] ERROR");
      $finish;
    end
  end

  initial begin
    int phase;
    int phase_end;
    int len;
    logic [3:0] nb;

    script[0]  = '{ONES, 4'd0, 1'b1, 1'b0, 64'h0};
    script[1]  = '{ONES, 4'd8, 1'b1, 1'b0, 64'h0};
    script[2]  = '{64'h0, 4'd15, 1'b1, 1'b0, 64'h0};
    script[3]  = '{64'haaaa_aaaa_aaaa_aaaa, 4'd3, 1'b0, 1'b0, 64'h0};
    script[4]  = '{64'h5555_5555_5555_5555, 4'd9, 1'b0, 1'b0, 64'h0};
    script[5]  = '{64'h0123_4567_89ab_cdef, 4'd7, 1'b1, 1'b0, 64'h0};
    script[6]  = '{64'hdead_beef_cafe_f00d, 4'd0, 1'b1, 1'b1, 64'h726fdb47dd0e0e31};
    script[7]  = '{64'hffff_ffff_ffff_ff00, 4'd1, 1'b1, 1'b1, 64'h74f839c593dc67fd};
    script[8]  = '{STD_KEY_LOW, 4'd8, 1'b1, 1'b0, 64'h0};
    script[9]  = '{STD_KEY_LOW, 4'd0, 1'b0, 1'b0, 64'h0};
    script[10] = '{STD_KEY_HIGH, 4'd6, 1'b1, 1'b0, 64'h0};
    script[11] = '{64'h0, 4'd8, 1'b0, 1'b0, 64'h0};
    script[12] = '{ONES, 4'd8, 1'b0, 1'b0, 64'h0};
    script[13] = '{64'h8000_0000_0000_0001, 4'd1, 1'b1, 1'b0, 64'h0};
    script[14] = '{ONES, 4'd2, 1'b1, 1'b0, 64'h0};
    script[15] = '{ONES, 4'd4, 1'b1, 1'b0, 64'h0};
    script[16] = '{64'h0f0f_0f0f_f0f0_f0f0, 4'd5, 1'b1, 1'b0, 64'h0};
    script[17] = '{ONES, 4'd3, 1'b1, 1'b0, 64'h0};
    script[18] = '{64'h1234_5678_9abc_def0, 4'd12, 1'b1, 1'b0, 64'h0};
    script[19] = '{ONES, 4'd8, 1'b0, 1'b0, 64'h0};

    key_lo = '0;
    key_hi = '0;
    restart_hash();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == STD_KEY_ROW) begin
        drain();
        apply_key(REG_KEY_LOW, STD_KEY_LOW);
        apply_key(REG_KEY_HIGH, STD_KEY_HIGH);
      end
      push_beat(script[i].word, script[i].nbytes, script[i].last,
                script[i].typed, script[i].hash);
    end
    // the open message from the last row is abandoned by the key write
    drain();

    phase = 0;
    beats = 0;
    while (beats < RANDOM_BEATS) begin
      case (phase % 5)
        0: begin apply_key(REG_KEY_LOW, ONES); apply_key(REG_KEY_HIGH, ONES); end
        1: begin apply_key(REG_KEY_LOW, '0); apply_key(REG_KEY_HIGH, '0); end
        2: apply_key(REG_KEY_LOW, {$urandom, $urandom});
        3: apply_key(REG_KEY_HIGH, {$urandom, $urandom});
        default: begin
          apply_key(REG_KEY_HIGH, {$urandom, $urandom});
          apply_key(REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      src_hurry  = ($urandom_range(0, 2) == 0);
      sink_hurry = ($urandom_range(0, 2) == 0);
      phase_end = beats + $urandom_range(120, 260);
      while (beats < phase_end && beats < RANDOM_BEATS) begin
        if ($urandom_range(0, 6) == 0) begin
          push_beat(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'b0, '0);
        end else begin
          len = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 4);
          for (int k = 0; k < len; k++) begin
            nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
            push_beat(rand_word(), nb, 1'b0, 1'b0, '0);
          end
          nb = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 8));
          push_beat(rand_word(), nb, 1'b1, 1'b0, '0);
        end
      end
      drain();
      phase++;
    end

    if (pending_hashes.size() != 0) begin
      $error("%0d expected hash_value beats never arrived", pending_hashes.size());
      errs++;
    end
    $display("covered %0d directed rows plus %0d random beats over %0d key settings,",
             NUM_ROWS, beats, phase);
    $display("%0d hashes compared, %0d key register writes", hashes, key_writes);
    if (errs == 0) begin
      $display("[siphash_keyed_stream_hash_top] OK");
    end else begin
      $display("[siphash_keyed_stream_hash_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/shk_pkg.sv
src/shk_front.sv
src/shk_queue.sv
src/shk_back.sv
src/siphash_keyed_stream_hash_top.sv
tb/tb_siphash_keyed_stream_hash_top.sv
